[rtl/bpsd_pkg.sv]
package bpsd_pkg;

  localparam int WINDOW_DEF      = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // Input opcodes
  localparam logic OP_PAIR     = 1'b0;
  localparam logic OP_LOSTSYNC = 1'b1;

  // Phase modes
  localparam logic [1:0] MODE_COPY   = 2'd0;
  localparam logic [1:0] MODE_SKIP   = 2'd1;
  localparam logic [1:0] MODE_NOSKIP = 2'd2;

  // Configuration register indexes
  localparam logic REG_MARGIN = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  localparam logic [4:0] MARGIN_RST = 5'd6;
  localparam logic [3:0] PERIOD_RST = 4'd5;

  localparam logic signed [5:0] TALLY_MAX = 6'sd31;
  localparam logic signed [5:0] TALLY_MIN = -6'sd31;

  typedef struct packed {
    logic [4:0] decision_margin;
    logic [3:0] sync_period;
  } cfg_t;

endpackage

[rtl/bpsd_lane.sv]
module bpsd_lane #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0] minuend,
  input  logic signed [SAMPLE_BITS-1:0] subtrahend,
  output logic signed [SAMPLE_BITS:0]   diff,
  output logic        [SAMPLE_BITS:0]   mag
);

  assign diff = (SAMPLE_BITS+1)'(minuend) - (SAMPLE_BITS+1)'(subtrahend);
  // diff never reaches the most negative code, so negation stays in range
  assign mag  = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : diff;

endmodule

[rtl/bpsd_merge.sv]
module bpsd_merge #(
  parameter int WINDOW      = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pair_accept,
  input  logic                          lostsync_accept,
  input  bpsd_pkg::cfg_t                cfg,
  input  logic signed [SAMPLE_BITS-1:0] sample_even,
  input  logic signed [SAMPLE_BITS-1:0] sample_odd,
  input  logic signed [SAMPLE_BITS:0]   skip_diff,
  input  logic        [SAMPLE_BITS:0]   skip_mag,
  input  logic signed [SAMPLE_BITS:0]   noskip_diff,
  input  logic        [SAMPLE_BITS:0]   noskip_mag,
  output logic signed [SAMPLE_BITS-1:0] prev_odd,
  output logic signed [SAMPLE_BITS:0]   res_sample,
  output logic        [1:0]             res_mode
);
  import bpsd_pkg::*;

  localparam int PW = $clog2(WINDOW);
  localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);

  logic [1:0]             mode_r, mode_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_odd_r;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic signed [5:0]      tally_r, tally_nxt, tally_upd;
  logic [3:0]             period_r, period_nxt;
  logic                   win_end;
  logic signed [6:0]      tally_w, margin_w;

  assign prev_odd = prev_odd_r;

  always_comb begin
    case (mode_r)
      MODE_SKIP: begin
        res_sample = skip_diff;
        res_mode   = MODE_SKIP;
      end
      MODE_NOSKIP: begin
        res_sample = noskip_diff;
        res_mode   = MODE_NOSKIP;
      end
      default: begin
        res_sample = (SAMPLE_BITS+1)'(sample_even);
        res_mode   = MODE_COPY;
      end
    endcase
  end

  assign win_end = (pos_r == POS_LAST);

  always_comb begin
    if (skip_mag > noskip_mag) begin
      tally_upd = (tally_r < TALLY_MAX) ? tally_r + 6'sd1 : tally_r;
    end else begin
      tally_upd = (tally_r > TALLY_MIN) ? tally_r - 6'sd1 : tally_r;
    end
  end

  assign tally_w  = 7'(tally_upd);
  assign margin_w = signed'({2'b00, cfg.decision_margin});

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    tally_nxt  = tally_r;
    period_nxt = period_r;
    if (lostsync_accept) begin
      mode_nxt = MODE_COPY;
    end else if (pair_accept) begin
      if (win_end) begin
        pos_nxt   = '0;
        tally_nxt = '0;
        if (mode_r != MODE_SKIP && mode_r != MODE_NOSKIP) begin
          if (period_r >= cfg.sync_period) begin
            period_nxt = '0;
            if (tally_w > margin_w) begin
              mode_nxt = MODE_SKIP;
            end else if (tally_w + margin_w < 7'sd0) begin
              mode_nxt = MODE_NOSKIP;
            end else begin
              mode_nxt = MODE_COPY;
            end
          end else begin
            period_nxt = period_r + 4'd1;
          end
        end
      end else begin
        pos_nxt   = pos_r + PW'(1);
        tally_nxt = tally_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_COPY;
      prev_odd_r <= '0;
      pos_r      <= '0;
      tally_r    <= '0;
      period_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tally_r  <= tally_nxt;
      period_r <= period_nxt;
      if (pair_accept) begin
        prev_odd_r <= sample_odd;
      end
    end
  end

endmodule

[rtl/biphase_phase_sync_decimator.sv]
// A pair's result is registered at the output, or in the skid register on output stall.
// Throughput: one item per cycle while in_stall is low; the skip and noskip lanes
// and the phase tally settle in the accepting cycle; a skid register holds one result.
// Lost-sync items give no result.
// Reset (rst_n low, synchronous): copy mode, window/tally/period cleared,
// previous odd sample zero, decision_margin 6, sync_period 5, output empty.
module biphase_phase_sync_decimator #(
  parameter int WINDOW      = bpsd_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = bpsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_even,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_odd,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS:0]   out_sample_out,
  output logic        [1:0]             out_mode_used,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic        [4:0]             cfg_data
);
  import bpsd_pkg::*;

  cfg_t cfg_r;

  logic                          accept, pair_accept, lostsync_accept;
  logic signed [SAMPLE_BITS-1:0] prev_odd;
  logic signed [SAMPLE_BITS:0]   skip_diff, noskip_diff, res_sample;
  logic        [SAMPLE_BITS:0]   skip_mag, noskip_mag;
  logic        [1:0]             res_mode;

  logic                          out_valid_r, skid_valid_r;
  logic signed [SAMPLE_BITS:0]   out_sample_r, skid_sample_r;
  logic        [1:0]             out_mode_r, skid_mode_r;
  logic                          out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decision_margin <= MARGIN_RST;
      cfg_r.sync_period     <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MARGIN: cfg_r.decision_margin <= cfg_data;
        REG_PERIOD: cfg_r.sync_period     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign in_stall        = skid_valid_r;
  assign accept          = in_valid && !in_stall;
  assign pair_accept     = accept && (in_opcode == OP_PAIR);
  assign lostsync_accept = accept && (in_opcode == OP_LOSTSYNC);

  bpsd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_skip (
    .minuend    (prev_odd),
    .subtrahend (in_sample_even),
    .diff       (skip_diff),
    .mag        (skip_mag)
  );

  bpsd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_noskip (
    .minuend    (in_sample_even),
    .subtrahend (in_sample_odd),
    .diff       (noskip_diff),
    .mag        (noskip_mag)
  );

  bpsd_merge #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .pair_accept     (pair_accept),
    .lostsync_accept (lostsync_accept),
    .cfg             (cfg_r),
    .sample_even     (in_sample_even),
    .sample_odd      (in_sample_odd),
    .skip_diff       (skip_diff),
    .skip_mag        (skip_mag),
    .noskip_diff     (noskip_diff),
    .noskip_mag      (noskip_mag),
    .prev_odd        (prev_odd),
    .res_sample      (res_sample),
    .res_mode        (res_mode)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      // skid drains first; input is stalled while it is full
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= pair_accept;
      end
    end else if (pair_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_sample_r <= skid_sample_r;
        out_mode_r   <= skid_mode_r;
      end else if (pair_accept) begin
        out_sample_r <= res_sample;
        out_mode_r   <= res_mode;
      end
    end else if (pair_accept) begin
      skid_sample_r <= res_sample;
      skid_mode_r   <= res_mode;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_mode_used  = out_mode_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output is empty");

  a_pair_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    pair_accept |=> out_valid_r)
    else $error("accepted pair produced no output");

  a_copy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mode_used == MODE_COPY) |->
      (out_sample_out[SAMPLE_BITS] == out_sample_out[SAMPLE_BITS-1]))
    else $error("copy-mode output is not a sign-extended sample");

endmodule

[sim/biphase_phase_sync_decimator_checker.sv]
module biphase_phase_sync_decimator_checker (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  input  logic                                        in_stall,
  input  logic                                        in_opcode,
  input  logic signed [bpsd_pkg::SAMPLE_BITS_DEF-1:0] in_sample_even,
  input  logic signed [bpsd_pkg::SAMPLE_BITS_DEF-1:0] in_sample_odd,
  input  logic                                        out_valid,
  input  logic                                        out_stall,
  input  logic signed [bpsd_pkg::SAMPLE_BITS_DEF:0]   out_sample_out,
  input  logic        [1:0]                           out_mode_used,
  input  logic                                        cfg_we,
  input  logic                                        cfg_index,
  input  logic        [4:0]                           cfg_data,
  output int                                          mismatch_count,
  output int                                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpsd_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF:0] sample;
    logic [1:0]                      mode;
  } decim_t;

  decim_t                          decimated_q[$];

  logic [1:0]                      phase_mode;
  logic signed [SAMPLE_BITS_DEF-1:0] last_odd;
  int                              window_pos;
  int                              skip_tally;
  logic [3:0]                      waited_windows;
  logic [4:0]                      margin;
  logic [3:0]                      period;

  initial begin
    mismatch_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic decimate_pair(input logic signed [SAMPLE_BITS_DEF-1:0] even,
                               input logic signed [SAMPLE_BITS_DEF-1:0] odd);
    int     skip_d;
    int     noskip_d;
    int     value;
    int     skip_mag;
    int     noskip_mag;
    decim_t r;
    skip_d   = int'(last_odd) - int'(even);
    noskip_d = int'(even) - int'(odd);
    case (phase_mode)
      MODE_SKIP: begin
        value  = skip_d;
        r.mode = MODE_SKIP;
      end
      MODE_NOSKIP: begin
        value  = noskip_d;
        r.mode = MODE_NOSKIP;
      end
      default: begin
        value  = int'(even);
        r.mode = MODE_COPY;
      end
    endcase
    r.sample = value[SAMPLE_BITS_DEF:0];
    decimated_q.push_back(r);

    skip_mag   = skip_d < 0 ? -skip_d : skip_d;
    noskip_mag = noskip_d < 0 ? -noskip_d : noskip_d;
    if (skip_mag > noskip_mag) begin
      if (skip_tally < int'(TALLY_MAX)) skip_tally++;
    end else begin
      if (skip_tally > int'(TALLY_MIN)) skip_tally--;
    end
    last_odd = odd;

    if (window_pos + 1 >= WINDOW_DEF) begin
      // decide only from copy mode, once enough windows have been waited
      if (phase_mode != MODE_SKIP && phase_mode != MODE_NOSKIP) begin
        if (waited_windows >= period) begin
          waited_windows = '0;
          if (skip_tally > int'(margin))
            phase_mode = MODE_SKIP;
          else if (skip_tally < -int'(margin))
            phase_mode = MODE_NOSKIP;
          else
            phase_mode = MODE_COPY;
        end else begin
          waited_windows = waited_windows + 4'd1;
        end
      end
      window_pos = 0;
      skip_tally = 0;
    end else begin
      window_pos++;
    end
  endtask

  always @(posedge clk) begin
    decim_t want;
    if (!rst_n) begin
      decimated_q.delete();
      phase_mode     = MODE_COPY;
      last_odd       = '0;
      window_pos     = 0;
      skip_tally     = 0;
      waited_windows = '0;
      margin         = MARGIN_RST;
      period         = PERIOD_RST;
    end else begin
      // a result seen at this edge belongs to an earlier item, so check it first
      if (out_valid && !out_stall) begin
        if (decimated_q.size() == 0) begin
          report_mismatch("unexpected result sample", int'(out_sample_out), 0);
        end else begin
          want = decimated_q.pop_front();
          if (out_sample_out !== want.sample)
            report_mismatch("sample_out", int'(out_sample_out), int'(want.sample));
          if (out_mode_used !== want.mode)
            report_mismatch("mode_used", int'(out_mode_used), int'(want.mode));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_MARGIN)
          margin = cfg_data;
        else
          period = cfg_data[3:0];
      end
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_LOSTSYNC)
          phase_mode = MODE_COPY;
        else
          decimate_pair(in_sample_even, in_sample_odd);
      end
    end
    pending <= decimated_q.size();
  end

endmodule

[sim/biphase_phase_sync_decimator_tb.sv]
module biphase_phase_sync_decimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB          = bpsd_pkg::SAMPLE_BITS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 125;

  localparam int BIAS_SKIP   = 0;
  localparam int BIAS_NOSKIP = 1;
  localparam int BIAS_MIXED  = 2;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_opcode      = bpsd_pkg::OP_PAIR;
  logic signed [SB-1:0] in_sample_even = '0;
  logic signed [SB-1:0] in_sample_odd  = '0;
  logic                 out_stall      = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic                 cfg_index      = bpsd_pkg::REG_MARGIN;
  logic [4:0]           cfg_data       = '0;

  wire                  in_stall;
  wire                  out_valid;
  wire signed [SB:0]    out_sample_out;
  wire [1:0]            out_mode_used;

  int                   mismatch_count;
  int                   pending;
  int                   idle_pct  = 0;
  int                   stall_pct = 0;
  int                   quiet_cycles = 0;
  int                   bias = BIAS_SKIP;
  // last odd sample sent; the block keeps the same one for its skip lane
  logic signed [SB-1:0] sent_odd = '0;

  biphase_phase_sync_decimator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_sample_even (in_sample_even),
    .in_sample_odd  (in_sample_odd),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_mode_used  (out_mode_used),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  biphase_phase_sync_decimator_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_sample_even (in_sample_even),
    .in_sample_odd  (in_sample_odd),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_mode_used  (out_mode_used),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("biphase_phase_sync_decimator test failed");
      $finish;
    end
  end

  task automatic write_thresholds(input logic [4:0] margin, input logic [3:0] period);
    cfg_we    <= 1'b1;
    cfg_index <= bpsd_pkg::REG_MARGIN;
    cfg_data  <= margin;
    @(posedge clk);
    cfg_index <= bpsd_pkg::REG_PERIOD;
    cfg_data  <= {1'b0, period};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_item(input logic op, input logic signed [SB-1:0] even,
                           input logic signed [SB-1:0] odd);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_sample_even <= even;
    in_sample_odd  <= odd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == bpsd_pkg::OP_PAIR) sent_odd = odd;
  endtask

  // hold the sender until every result is out, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(23))
      0:       return {1'b1, {(SB-1){1'b0}}};
      1:       return {1'b0, {(SB-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic random_item();
    int                   roll;
    logic signed [SB-1:0] even;
    logic signed [SB-1:0] odd;
    if ($urandom_range(79) == 0) bias = $urandom_range(BIAS_MIXED);
    roll = $urandom_range(99);
    if (roll < 3) begin
      send_item(bpsd_pkg::OP_LOSTSYNC, pick_sample(), pick_sample());
    end else if (roll < 12 || bias == BIAS_MIXED) begin
      send_item(bpsd_pkg::OP_PAIR, pick_sample(), pick_sample());
    end else if (bias == BIAS_SKIP) begin
      // odd close to even: the noskip difference stays small
      even = pick_sample();
      odd  = even ^ SB'($urandom_range(3));
      send_item(bpsd_pkg::OP_PAIR, even, odd);
    end else begin
      // even close to the previous odd: the skip difference stays small
      even = sent_odd ^ SB'($urandom_range(3));
      send_item(bpsd_pkg::OP_PAIR, even, pick_sample());
    end
  endtask

  initial begin
    logic signed [SB-1:0] extreme;
    logic [4:0]           margins [PHASES];
    logic [3:0]           periods [PHASES];
    margins = '{5'd6, 5'd16, 5'd31, 5'd0, 5'd3, 5'd0, 5'd1, 5'd16};
    periods = '{4'd5, 4'd15, 4'd0, 4'd1, 4'd2, 4'd0, 4'd0, 4'd3};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // decide at every window with no margin, so one window of skip-favoring pairs
    // moves the block to skip mode
    write_thresholds(5'd0, 4'd0);
    send_item(bpsd_pkg::OP_LOSTSYNC, '0, '0);
    for (int i = 0; i < bpsd_pkg::WINDOW_DEF; i++) begin
      extreme = i[0] ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
      send_item(bpsd_pkg::OP_PAIR, extreme, extreme);
    end
    send_item(bpsd_pkg::OP_PAIR, {1'b1, {(SB-1){1'b0}}}, {1'b0, {(SB-1){1'b1}}});
    send_item(bpsd_pkg::OP_PAIR, {1'b0, {(SB-1){1'b1}}}, {1'b1, {(SB-1){1'b0}}});
    send_item(bpsd_pkg::OP_PAIR, {1'b0, {(SB-1){1'b1}}}, '0);
    send_item(bpsd_pkg::OP_PAIR, '0, '1);
    send_item(bpsd_pkg::OP_LOSTSYNC, '1, '1);
    send_item(bpsd_pkg::OP_PAIR, '1, '0);
    drain();

    margins[5] = 5'($urandom_range(16));
    periods[5] = 4'($urandom_range(15));
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      write_thresholds(margins[ph], periods[ph]);
      bias = $urandom_range(BIAS_MIXED);
      repeat (PHASE_ITEMS) random_item();
      drain();
    end

    if (mismatch_count == 0 && pending == 0)
      $display("biphase_phase_sync_decimator test passed");
    else
      $display("biphase_phase_sync_decimator test failed");
    $finish;
  end

endmodule

[biphase_phase_sync_decimator.f]
rtl/bpsd_pkg.sv
rtl/bpsd_lane.sv
rtl/bpsd_merge.sv
rtl/biphase_phase_sync_decimator.sv
sim/biphase_phase_sync_decimator_checker.sv
sim/biphase_phase_sync_decimator_tb.sv
